/* sv/nsp_pkg.sv */
// nsp_pkg: shared types, codes and widths for the nearest shape picker
// no dependencies; imported by every module of the block

package nsp_pkg;

  // fixed field widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned HALF_W   = 15;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned DIST_W   = 33;
  localparam int unsigned CFG_IDX_W = 1;

  // widened coordinate: sums and doubled offsets of two coordinates
  localparam int unsigned WIDE_W   = COORD_W + 2;
  localparam int unsigned MAG_W    = WIDE_W - 1;
  localparam int unsigned SQ_W     = 2 * MAG_W;
  localparam int unsigned METRIC_W = SQ_W;

  // shape count limit per query
  localparam int unsigned MAX_SHAPES = 1024;
  localparam int unsigned CNT_W      = $clog2(MAX_SHAPES + 1);

  // register reset values
  localparam logic [HALF_W-1:0] TEXT_HALF_W_RST = HALF_W'(192);
  localparam logic [HALF_W-1:0] TEXT_HALF_H_RST = HALF_W'(77);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SHAPE  = 2'd1,
    OP_FINISH = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINE    = 3'd0,
    KIND_RECT    = 3'd1,
    KIND_ELLIPSE = 3'd2,
    KIND_TRI     = 3'd3,
    KIND_TEXT    = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_HALF_W = 1'd0,
    CFG_TEXT_HALF_H = 1'd1
  } cfg_idx_e;

  // request payload
  typedef struct packed {
    op_e                       op;
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } nsp_in_t;

  // result payload
  typedef struct packed {
    logic                found;
    logic [KIND_W-1:0]   hit_kind;
    logic [INDEX_W-1:0]  hit_index;
    logic [DIST_W-1:0]   dist_metric;
  } nsp_out_t;

  // geometry stage result, handed to the tracker
  typedef struct packed {
    op_e               op;
    logic [KIND_W-1:0] kind;
    logic              kind_ok;
    logic              in_box;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
  } shape_res_t;

endpackage

/* sv/nsp_geom.sv */
// nsp_geom: box test and squared doubled offsets for one shape request
// depends on nsp_pkg

module nsp_geom (
  input  nsp_pkg::nsp_in_t                     item_i,
  input  logic signed [nsp_pkg::COORD_W-1:0]   ptr_x_i,
  input  logic signed [nsp_pkg::COORD_W-1:0]   ptr_y_i,
  input  logic [nsp_pkg::HALF_W-1:0]           half_w_i,
  input  logic [nsp_pkg::HALF_W-1:0]           half_h_i,
  output nsp_pkg::shape_res_t                  res_o
);
  import nsp_pkg::*;

  logic signed [WIDE_W-1:0] px, py, ax, ay, bx, by, hw, hh;
  logic signed [WIDE_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [WIDE_W-1:0] off_x, off_y;
  logic [MAG_W-1:0]         mag_x, mag_y;
  logic                     in_x, in_y;

  always_comb begin
    px = WIDE_W'(ptr_x_i);
    py = WIDE_W'(ptr_y_i);
    ax = WIDE_W'(item_i.ax);
    ay = WIDE_W'(item_i.ay);
    bx = WIDE_W'(item_i.bx);
    by = WIDE_W'(item_i.by);
    hw = $signed({{(WIDE_W-HALF_W){1'b0}}, half_w_i});
    hh = $signed({{(WIDE_W-HALF_W){1'b0}}, half_h_i});

    res_o.kind_ok = 1'b1;
    case (item_i.kind) inside
      KIND_ELLIPSE: begin
        lo_x  = ax - bx;
        hi_x  = ax + bx;
        lo_y  = ay - by;
        hi_y  = ay + by;
        off_x = (px <<< 1) - (ax <<< 1);
        off_y = (py <<< 1) - (ay <<< 1);
      end
      KIND_TEXT: begin
        lo_x  = ax - hw;
        hi_x  = ax + hw;
        lo_y  = ay - hh;
        hi_y  = ay + hh;
        off_x = (px <<< 1) - (ax <<< 1);
        off_y = (py <<< 1) - (ay <<< 1);
      end
      KIND_LINE, KIND_RECT, KIND_TRI: begin
        lo_x  = ax;
        hi_x  = bx;
        lo_y  = ay;
        hi_y  = by;
        off_x = (px <<< 1) - (ax + bx);
        off_y = (py <<< 1) - (ay + by);
      end
      default: begin
        // unused kind codes: dropped and not counted
        res_o.kind_ok = 1'b0;
        lo_x  = ax;
        hi_x  = bx;
        lo_y  = ay;
        hi_y  = by;
        off_x = (px <<< 1) - (ax + bx);
        off_y = (py <<< 1) - (ay + by);
      end
    endcase

    // inclusive edges, corners in either order
    in_x = (lo_x <= hi_x) ? (px >= lo_x && px <= hi_x) : (px >= hi_x && px <= lo_x);
    in_y = (lo_y <= hi_y) ? (py >= lo_y && py <= hi_y) : (py >= hi_y && py <= lo_y);

    mag_x = off_x[WIDE_W-1] ? MAG_W'(-off_x) : MAG_W'(off_x);
    mag_y = off_y[WIDE_W-1] ? MAG_W'(-off_y) : MAG_W'(off_y);

    res_o.op     = item_i.op;
    res_o.kind   = item_i.kind;
    res_o.in_box = in_x && in_y;
    res_o.sq_x   = SQ_W'(mag_x) * SQ_W'(mag_x);
    res_o.sq_y   = SQ_W'(mag_y) * SQ_W'(mag_y);
  end

endmodule

/* sv/nsp_track.sv */
// nsp_track: running nearest-hit search, shape counter and result register
// depends on nsp_pkg

module nsp_track (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  nsp_pkg::shape_res_t   item_i,
  input  logic                  out_stall_i,
  output logic                  out_free_o,
  output logic                  out_valid_o,
  output nsp_pkg::nsp_out_t     out_data_o
);
  import nsp_pkg::*;

  localparam logic [CNT_W-1:0]    SHAPE_LIMIT = CNT_W'(MAX_SHAPES);
  localparam logic [METRIC_W-1:0] DIST_MAX    = METRIC_W'({DIST_W{1'b1}});

  logic [METRIC_W-1:0] best_metric_q;
  logic [KIND_W-1:0]   best_kind_q;
  logic [INDEX_W-1:0]  best_index_q;
  logic [CNT_W-1:0]    count_q;
  logic                have_hit_q;
  logic                out_valid_q;
  nsp_out_t            out_q, out_d;
  logic [SQ_W:0]       sum;
  logic [METRIC_W-1:0] metric;
  logic                counted;
  logic                is_finish;

  always_comb begin
    sum       = {1'b0, item_i.sq_x} + {1'b0, item_i.sq_y};
    metric    = sum[METRIC_W-1:0];
    counted   = item_i.kind_ok && (count_q < SHAPE_LIMIT);
    is_finish = (item_i.op == OP_FINISH);

    out_d = '0;
    if (have_hit_q) begin
      out_d.found       = 1'b1;
      out_d.hit_kind    = best_kind_q;
      out_d.hit_index   = best_index_q;
      out_d.dist_metric = (best_metric_q > DIST_MAX) ? {DIST_W{1'b1}}
                                                     : best_metric_q[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_metric_q <= '1;
      best_kind_q   <= '0;
      best_index_q  <= '0;
      count_q       <= '0;
      have_hit_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (take_i) begin
        unique case (item_i.op)
          OP_START: begin
            best_metric_q <= '1;
            best_kind_q   <= '0;
            best_index_q  <= '0;
            count_q       <= '0;
            have_hit_q    <= 1'b0;
          end
          OP_SHAPE: begin
            if (counted) begin
              count_q <= count_q + CNT_W'(1);
              if (item_i.in_box && (metric < best_metric_q)) begin
                best_metric_q <= metric;
                best_kind_q   <= item_i.kind;
                best_index_q  <= count_q[INDEX_W-1:0];
                have_hit_q    <= 1'b1;
              end
            end
          end
          OP_FINISH: begin
          end
          OP_NOP: begin
          end
        endcase
      end
      if (take_i && is_finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a finish request retires
  always_ff @(posedge clk_i) begin
    if (take_i && is_finish) begin
      out_q <= out_d;
    end
  end

  assign out_free_o  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/nearest_shape_picker_top.sv */
// nearest_shape_picker_top: top level of the nearest shape picker
// depends on nsp_pkg, nsp_geom and nsp_track
//
// usage
//   requests come in on in_valid_i / in_stall_o / in_data_i and are taken
//   at an edge with valid high and stall low. a start request loads the
//   pointer and clears the search, shape requests are box-tested against
//   the pointer and the nearest hit is kept (earliest wins a tie), and a
//   finish request emits one result on out_valid_o / out_stall_i /
//   out_data_o. start and shape requests emit nothing.
//   the user writes the text hit box half sizes on cfg_we_i / cfg_index_i /
//   cfg_wdata_i while the block is idle; the block does not enforce it.
// timing
//   three register stages: input, geometry (box test and squares), search
//   and result. a finish result is held in the result register. one request
//   a cycle sustained while no finish waits on a stalled result; the
//   squared-offset multipliers in the geometry stage and the metric add
//   and compare in the search stage set the cycle.
// reset and stall
//   reset empties the pipe, clears the pointer and the search and loads
//   the default text box. a stalled result holds; the pipe keeps taking
//   requests until a finish has to wait behind it.

module nearest_shape_picker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  nsp_pkg::nsp_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output nsp_pkg::nsp_out_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [nsp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nsp_pkg::HALF_W-1:0]      cfg_wdata_i
);
  import nsp_pkg::*;

  // input stage
  logic     s0_valid_q;
  nsp_in_t  s0_q;
  // geometry stage
  logic       s1_valid_q;
  shape_res_t s1_q, s1_d;

  // pointer, owned by the geometry stage so shapes see every earlier start
  logic signed [COORD_W-1:0] ptr_x_q, ptr_y_q;
  logic [HALF_W-1:0]         half_w_q, half_h_q;

  // handshake chain
  logic out_free;
  logic s1_go, s1_free;
  logic s0_go, s0_free;
  logic accept;

  assign s1_go   = s1_valid_q && ((s1_q.op != OP_FINISH) || out_free);
  assign s1_free = !s1_valid_q || s1_go;
  assign s0_go   = s0_valid_q && s1_free;
  assign s0_free = !s0_valid_q || s0_go;
  assign accept  = in_valid_i && s0_free;
  assign in_stall_o = !s0_free;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_w_q <= TEXT_HALF_W_RST;
      half_h_q <= TEXT_HALF_H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEXT_HALF_W: half_w_q <= cfg_wdata_i;
        CFG_TEXT_HALF_H: half_h_q <= cfg_wdata_i;
      endcase
    end
  end

  // stage valids and pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      ptr_x_q    <= '0;
      ptr_y_q    <= '0;
    end else begin
      if (accept) begin
        s0_valid_q <= 1'b1;
      end else if (s0_go) begin
        s0_valid_q <= 1'b0;
      end
      if (s0_go) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      // start moves the pointer as it leaves the input stage
      if (s0_go && (s0_q.op == OP_START)) begin
        ptr_x_q <= s0_q.ax;
        ptr_y_q <= s0_q.ay;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_q <= in_data_i;
    end
    if (s0_go) begin
      s1_q <= s1_d;
    end
  end

  nsp_geom u_geom (
    .item_i   (s0_q),
    .ptr_x_i  (ptr_x_q),
    .ptr_y_i  (ptr_y_q),
    .half_w_i (half_w_q),
    .half_h_i (half_h_q),
    .res_o    (s1_d)
  );

  nsp_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (s1_go),
    .item_i      (s1_q),
    .out_stall_i (out_stall_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
